// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, masked while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dif_pkg.sv -----
// ---------------------------------------------------------------------------
// Decimal formatter package
// Request and result types, state encoding and character codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dif_pkg;

  localparam int VALUE_W         = 32;
  localparam int FIELD_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int BCD_DIGITS      = 10;
  localparam int FIELD_LIMIT_DEF = 48;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
    logic               half_length;
    logic               left_align;
    logic               force_plus;
    logic               space_sign;
    logic [FIELD_W-1:0] field_width;
    logic [FIELD_W-1:0] digit_count;
    logic               precision_given;
  } dif_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } dif_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } dif_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/decimal_integer_formatter_core.sv -----
// ---------------------------------------------------------------------------
// Decimal integer formatter core
// Renders one 32-bit word as printf-style decimal text, one character per
// result request, with sign, precision and field-width padding.
// ---------------------------------------------------------------------------
//
//  channel | ports                       | direction | carries
//  --------+-----------------------------+-----------+-------------------------
//  input   | in_valid, in_stall, in_data | in        | value and format flags
//  output  | out_valid, out_stall,out_data| out      | one character, last mark
//
//  Steps: a request is taken in the idle state, then one shift-and-add-3 step
//  per input bit of binary to BCD conversion (one shared adjust/shift unit over
//  ten digits), a sizing state, then one character per cycle while the output
//  does not stall. A request that yields no text (zero, precision 0, no sign,
//  width 0) passes through conversion and sizing and produces nothing.
//  Reset clears the sequencer and the output valid; no memory is cleared.
//  in_stall is high from acceptance until the last character sits in the
//  output register; a stalled output holds its character and pauses emission,
//  while the last character may wait as the next request enters.
//
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module decimal_integer_formatter_core
  import dif_pkg::*;
#(
  parameter int FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dif_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dif_out_t      out_data
);

  // Counts of characters reach FIELD_LIMIT + 1 at most while FIELD_LIMIT is ten or more.
  localparam int CW   = $clog2(FIELD_LIMIT + 2);
  localparam int CNTW = $clog2(VALUE_W);
  localparam int DIW  = $clog2(BCD_DIGITS);

  localparam logic [FIELD_W-1:0] LIMIT_F = FIELD_W'(FIELD_LIMIT);

  dif_state_t state_r, state_nxt;

  logic [CNTW-1:0]                  cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]               bin_r, bin_nxt;
  logic [BCD_DIGITS-1:0][3:0]       bcd_r, bcd_nxt;
  logic                             left_r, left_nxt;
  logic                             sign_on_r, sign_on_nxt;
  logic [CHAR_W-1:0]                sign_char_r, sign_char_nxt;
  logic [CW-1:0]                    width_r, width_nxt;
  logic [CW-1:0]                    prec_r, prec_nxt;
  logic [CW-1:0]                    lead_r, lead_nxt;
  logic [CW-1:0]                    dcnt_r, dcnt_nxt;
  logic [CW-1:0]                    rem_r, rem_nxt;
  logic                             out_valid_r, out_valid_nxt;
  dif_out_t                         out_data_r, out_data_nxt;

  // Request decode
  logic [VALUE_W-1:0]  val_ext;
  logic                val_neg;
  logic [VALUE_W-1:0]  val_mag;
  logic [FIELD_W-1:0]  width_sat;
  logic [FIELD_W-1:0]  prec_sat;

  // Conversion step
  logic [BCD_DIGITS-1:0][3:0] bcd_adj;

  // Sizing
  logic [3:0]    nsig;
  logic [CW-1:0] nd;
  logic [CW-1:0] body;
  logic [CW-1:0] pad;

  // Emission
  logic          emit_go;
  logic [CW-1:0] didx;
  logic [3:0]    digit;

  always_comb begin
    if (in_data.half_length) begin
      val_ext = {{(VALUE_W-16){in_data.signed_mode & in_data.value[15]}},
                 in_data.value[15:0]};
    end else begin
      val_ext = in_data.value;
    end
    val_neg   = in_data.signed_mode & val_ext[VALUE_W-1];
    // Most negative value wraps to its own magnitude modulo 2^32.
    val_mag   = val_neg ? (~val_ext + VALUE_W'(1)) : val_ext;
    width_sat = (in_data.field_width > LIMIT_F) ? LIMIT_F : in_data.field_width;
    prec_sat  = (in_data.digit_count > LIMIT_F) ? LIMIT_F : in_data.digit_count;
  end

  // Add 3 to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  // Number of significant digits; zero has none.
  always_comb begin
    nsig = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        nsig = 4'(i + 1);
      end
    end
    nd   = (CW'(nsig) > prec_r) ? CW'(nsig) : prec_r;
    body = nd + CW'(sign_on_r);
    pad  = (width_r > body) ? (width_r - body) : '0;
  end

  always_comb begin
    emit_go = !out_valid_r || !out_stall;
    didx    = dcnt_r - CW'(1);
    if (didx < CW'(BCD_DIGITS)) begin
      digit = bcd_r[didx[DIW-1:0]];
    end else begin
      digit = 4'd0;
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    left_nxt      = left_r;
    sign_on_nxt   = sign_on_r;
    sign_char_nxt = sign_char_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    lead_nxt      = lead_r;
    dcnt_nxt      = dcnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_stall      = (state_r != ST_IDLE);

    // Drop a character once the consumer has taken it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = val_mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          left_nxt  = in_data.left_align;
          width_nxt = CW'(width_sat);
          // Without an explicit precision at least one digit is printed.
          if (!in_data.precision_given && prec_sat == '0) begin
            prec_nxt = CW'(1);
          end else begin
            prec_nxt = CW'(prec_sat);
          end
          sign_on_nxt = val_neg | in_data.force_plus | in_data.space_sign;
          priority if (val_neg) begin
            sign_char_nxt = CHAR_MINUS;
          end else if (in_data.force_plus) begin
            sign_char_nxt = CHAR_PLUS;
          end else begin
            sign_char_nxt = CHAR_SPACE;
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(VALUE_W - 1)) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        lead_nxt = left_r ? '0 : pad;
        dcnt_nxt = nd;
        rem_nxt  = body + pad;
        // Empty text: nothing to emit.
        state_nxt = ((body + pad) == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.last_char = (rem_r == CW'(1));
          rem_nxt                = rem_r - CW'(1);
          priority if (lead_r != '0) begin
            out_data_nxt.text_char = CHAR_SPACE;
            lead_nxt               = lead_r - CW'(1);
          end else if (sign_on_r) begin
            out_data_nxt.text_char = sign_char_r;
            sign_on_nxt            = 1'b0;
          end else if (dcnt_r != '0) begin
            out_data_nxt.text_char = CHAR_ZERO + {3'b000, digit};
            dcnt_nxt               = dcnt_r - CW'(1);
          end else begin
            out_data_nxt.text_char = CHAR_SPACE;
          end
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    left_r      <= left_nxt;
    sign_on_r   <= sign_on_nxt;
    sign_char_r <= sign_char_nxt;
    width_r     <= width_nxt;
    prec_r      <= prec_nxt;
    lead_r      <= lead_nxt;
    dcnt_r      <= dcnt_nxt;
    rem_r       <= rem_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_emit_has_chars, state_r == ST_EMIT, rem_r != '0,
                  "emit phase entered with no characters left")
  `ASSERT_NEXT(a_conv_runs_full, state_r == ST_CONV && cnt_r != CNTW'(VALUE_W - 1),
               state_r == ST_CONV, "conversion left before all bits shifted")
  `ASSERT_NEXT(a_last_ends_request,
               state_r == ST_EMIT && emit_go && rem_r == CW'(1),
               state_r == ST_IDLE && out_valid_r && out_data_r.last_char,
               "last character did not close the request")

endmodule

`default_nettype wire
